FILE: rtl/pads_pkg.sv
// Package: item types, microcode format and constants for the deadline scheduler.
package pads_pkg;

    localparam int unsigned TIME_BITS = 63;
    localparam int unsigned IVL_BITS  = 32;
    localparam int unsigned SKIP_BITS = 32;
    localparam int unsigned PC_BITS   = 4;
    localparam int unsigned OP_BITS   = 4;
    localparam int unsigned JC_BITS   = 3;
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam int unsigned DIV_STEPS = TIME_BITS;

    localparam logic [TIME_BITS-1:0] MAX63          = {TIME_BITS{1'b1}};
    localparam logic [IVL_BITS-1:0]  INTERVAL_RESET = 32'd33333333;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_START    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 1'b1;

    typedef logic [OP_BITS-1:0] t_op;
    typedef logic [JC_BITS-1:0] t_jc;
    typedef logic [PC_BITS-1:0] t_pc;

    // Datapath operations
    localparam t_op OP_NOP      = 4'd0;
    localparam t_op OP_MUL_LO   = 4'd1;
    localparam t_op OP_MUL_HI   = 4'd2;
    localparam t_op OP_ACC_HI   = 4'd3;
    localparam t_op OP_TARGET   = 4'd4;
    localparam t_op OP_CHECK    = 4'd5;
    localparam t_op OP_DIV      = 4'd6;
    localparam t_op OP_SKIP     = 4'd7;
    localparam t_op OP_MUL_SKIP = 4'd8;
    localparam t_op OP_CATCHUP  = 4'd9;
    localparam t_op OP_DIFF     = 4'd10;
    localparam t_op OP_DEADLINE = 4'd11;
    localparam t_op OP_EMIT     = 4'd12;

    // Sequencing
    localparam t_jc JC_NEXT      = 3'd0;  // pc + 1
    localparam t_jc JC_GOTO      = 3'd1;  // always to target
    localparam t_jc JC_WAIT_IN   = 3'd2;  // hold until an item is taken, then next
    localparam t_jc JC_BR_ONTIME = 3'd3;  // to target when not late, else next
    localparam t_jc JC_LOOP      = 3'd4;  // to target while iterations remain
    localparam t_jc JC_WAIT_OUT  = 3'd5;  // hold until result slot frees, then target

    // Program addresses
    localparam t_pc S_IDLE     = 4'd0;
    localparam t_pc S_MUL_LO   = 4'd1;
    localparam t_pc S_MUL_HI   = 4'd2;
    localparam t_pc S_ACC_HI   = 4'd3;
    localparam t_pc S_TARGET   = 4'd4;
    localparam t_pc S_CHECK    = 4'd5;
    localparam t_pc S_DIV      = 4'd6;
    localparam t_pc S_SKIP     = 4'd7;
    localparam t_pc S_MUL_SKIP = 4'd8;
    localparam t_pc S_CATCHUP  = 4'd9;
    localparam t_pc S_DIFF     = 4'd10;
    localparam t_pc S_DEADLINE = 4'd11;
    localparam t_pc S_EMIT     = 4'd12;

    typedef struct packed {
        logic [TIME_BITS-1:0] wall_now_ns;
        logic [TIME_BITS-1:0] mono_now_ns;
    } t_in_item;

    typedef struct packed {
        logic [TIME_BITS-1:0] wall_target_ns;
        logic [TIME_BITS-1:0] mono_deadline_ns;
        logic                 late;
        logic [SKIP_BITS-1:0] skipped;
    } t_out_item;

    typedef struct packed {
        t_op  op;
        t_jc  cond;
        t_pc  target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic load_in;
    } t_dp_ctrl;

    typedef struct packed {
        logic ontime;     // nominal target still ahead of wall time
        logic loop_more;  // divider iterations remain after this one
    } t_dp_status;

    function automatic t_uword pads_uword(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_IDLE:     w = '{OP_NOP,      JC_WAIT_IN,   S_IDLE};
            S_MUL_LO:   w = '{OP_MUL_LO,   JC_NEXT,      S_IDLE};
            S_MUL_HI:   w = '{OP_MUL_HI,   JC_NEXT,      S_IDLE};
            S_ACC_HI:   w = '{OP_ACC_HI,   JC_NEXT,      S_IDLE};
            S_TARGET:   w = '{OP_TARGET,   JC_NEXT,      S_IDLE};
            S_CHECK:    w = '{OP_CHECK,    JC_BR_ONTIME, S_DIFF};
            S_DIV:      w = '{OP_DIV,      JC_LOOP,      S_DIV};
            S_SKIP:     w = '{OP_SKIP,     JC_NEXT,      S_IDLE};
            S_MUL_SKIP: w = '{OP_MUL_SKIP, JC_NEXT,      S_IDLE};
            S_CATCHUP:  w = '{OP_CATCHUP,  JC_NEXT,      S_IDLE};
            S_DIFF:     w = '{OP_DIFF,     JC_NEXT,      S_IDLE};
            S_DEADLINE: w = '{OP_DEADLINE, JC_NEXT,      S_IDLE};
            S_EMIT:     w = '{OP_EMIT,     JC_WAIT_OUT,  S_IDLE};
            default:    w = '{OP_NOP,      JC_GOTO,      S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/pads_datapath.sv
// Datapath: config, tick counter, shared 32x32 multiplier, radix-2 divider, saturating adds.
module pads_datapath
    import pads_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [TIME_BITS-1:0]    i_cfg_data,
    input  t_dp_ctrl                i_ctrl,
    input  t_in_item                i_item,
    output t_dp_status              o_status,
    output t_out_item               o_result
);

    localparam int unsigned ACC_BITS = IVL_BITS + 64;
    localparam logic [COUNT_BITS-1:0] TICK_ONE = COUNT_BITS'(1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

    logic [TIME_BITS-1:0]  r_start;
    logic [IVL_BITS-1:0]   r_interval;
    logic [COUNT_BITS-1:0] r_tick;
    logic [TIME_BITS-1:0]  r_wall, r_mono;
    logic [63:0]           r_prod;
    logic [ACC_BITS-1:0]   r_acc;
    logic [TIME_BITS-1:0]  r_target;
    logic                  r_late;
    logic [SKIP_BITS-1:0]  r_skip;
    logic [TIME_BITS-1:0]  r_quo;     // dividend shifts out, quotient shifts in
    logic [IVL_BITS-1:0]   r_rem;
    logic [5:0]            r_cnt;
    logic [63:0]           r_diff;
    logic [TIME_BITS-1:0]  r_dead;

    logic [63:0]           w_tick64;
    logic [63:0]           w_skip64;
    logic [IVL_BITS-1:0]   w_mul_b;
    logic [63:0]           w_mul;
    logic [TIME_BITS-1:0]  w_prod_sat;
    logic [63:0]           w_tgt_sum;
    logic [IVL_BITS:0]     w_trial;
    logic                  w_ge;
    logic [IVL_BITS:0]     w_trial_sub;
    logic [64:0]           w_catch_sum;
    logic [64:0]           w_dl_sum;

    always_comb begin
        w_tick64 = 64'(r_tick);
        w_skip64 = 64'(r_skip);
        unique case (i_ctrl.op)
            OP_MUL_LO: w_mul_b = w_tick64[31:0];
            OP_MUL_HI: w_mul_b = w_tick64[63:32];
            default:   w_mul_b = r_skip;
        endcase
        w_mul = 64'(r_interval) * 64'(w_mul_b);

        w_prod_sat = (|r_acc[ACC_BITS-1:TIME_BITS]) ? MAX63 : r_acc[TIME_BITS-1:0];
        w_tgt_sum  = {1'b0, r_start} + {1'b0, w_prod_sat};

        w_trial     = {r_rem, r_quo[TIME_BITS-1]};
        w_ge        = w_trial >= {1'b0, r_interval};
        w_trial_sub = w_trial - {1'b0, r_interval};

        w_catch_sum = {2'b00, r_target} + {1'b0, r_prod};
        w_dl_sum    = {2'b00, r_mono} + {r_diff[63], r_diff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_interval <= INTERVAL_RESET;
            r_tick     <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START:    r_start    <= i_cfg_data;
                    CFG_INTERVAL: r_interval <= i_cfg_data[IVL_BITS-1:0];
                    default:      ;
                endcase
            end
            unique case (i_ctrl.op)
                OP_TARGET:  r_tick <= r_tick + TICK_ONE;
                OP_CHECK:   r_cnt  <= DIV_LAST;
                OP_DIV:     r_cnt  <= r_cnt - 6'd1;
                OP_CATCHUP: r_tick <= r_tick + w_skip64[COUNT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_wall <= i_item.wall_now_ns;
            r_mono <= i_item.mono_now_ns;
        end
        unique case (i_ctrl.op)
            OP_MUL_LO: r_prod <= w_mul;
            OP_MUL_HI: begin
                r_acc  <= ACC_BITS'(r_prod);
                r_prod <= w_mul;
            end
            OP_ACC_HI: r_acc <= r_acc + {r_prod, 32'b0};
            OP_TARGET: r_target <= w_tgt_sum[63] ? MAX63 : w_tgt_sum[TIME_BITS-1:0];
            OP_CHECK: begin
                r_late <= !o_status.ontime;
                r_skip <= '0;
                r_quo  <= r_wall - r_target;
                r_rem  <= '0;
            end
            OP_DIV: begin
                r_rem <= w_ge ? w_trial_sub[IVL_BITS-1:0] : w_trial[IVL_BITS-1:0];
                r_quo <= {r_quo[TIME_BITS-2:0], w_ge};
            end
            // zero interval: quotient counts as zero
            OP_SKIP: r_skip <= (r_interval == '0) ? SKIP_BITS'(1)
                                                 : r_quo[SKIP_BITS-1:0] + SKIP_BITS'(1);
            OP_MUL_SKIP: r_prod <= w_mul;
            OP_CATCHUP: r_target <= (|w_catch_sum[64:63]) ? MAX63
                                                          : w_catch_sum[TIME_BITS-1:0];
            OP_DIFF: r_diff <= {1'b0, r_target} - {1'b0, r_wall};
            OP_DEADLINE: begin
                priority if (w_dl_sum[64]) begin
                    r_dead <= '0;
                end else if (w_dl_sum[63]) begin
                    r_dead <= MAX63;
                end else begin
                    r_dead <= w_dl_sum[TIME_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_status.ontime    = r_target > r_wall;
    assign o_status.loop_more = r_cnt != '0;

    assign o_result.wall_target_ns   = r_target;
    assign o_result.mono_deadline_ns = r_dead;
    assign o_result.late             = r_late;
    assign o_result.skipped          = r_skip;

endmodule

FILE: rtl/phase_aligned_deadline_scheduler.sv
// Top level: microcode sequencer, input handshake and result register.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in item  | i_in_valid, o_in_ready, i_in_item         | in
//  out item | o_out_valid, i_out_ready, o_out_item      | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// One item at a time. An on-time item goes from acceptance through the multiply,
// target, check, difference, deadline and emit steps; a late item also runs the
// 63-step radix-2 divider that finds how many intervals to skip, then catch-up.
// Reset is synchronous, active low; it restores start 0, interval 33333333, tick 0.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only the emit step holds until the register frees.
module phase_aligned_deadline_scheduler
    import pads_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [TIME_BITS-1:0]    i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_item
);

    t_pc        r_pc, n_pc;
    logic       r_out_valid;
    t_out_item  r_out;

    t_uword     w_uw;
    t_dp_ctrl   w_ctrl;
    t_dp_status w_status;
    t_out_item  w_result;
    logic       w_accept;
    logic       w_out_free;
    logic       w_emit;

    // Microcode fetch: the table is pure logic, indexed by the step counter.
    assign w_uw       = pads_uword(r_pc);
    assign o_in_ready = (r_pc == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (w_uw.op == OP_EMIT) && w_out_free;

    assign w_ctrl.op      = w_uw.op;
    assign w_ctrl.load_in = w_accept;

    // Next step
    always_comb begin
        unique case (w_uw.cond)
            JC_NEXT:      n_pc = r_pc + 1'b1;
            JC_GOTO:      n_pc = w_uw.target;
            JC_WAIT_IN:   n_pc = w_accept ? r_pc + 1'b1 : r_pc;
            JC_BR_ONTIME: n_pc = w_status.ontime ? w_uw.target : r_pc + 1'b1;
            JC_LOOP:      n_pc = w_status.loop_more ? w_uw.target : r_pc + 1'b1;
            JC_WAIT_OUT:  n_pc = w_out_free ? w_uw.target : r_pc;
            default:      n_pc = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            // emit wins over a take in the same cycle: slot refills
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    pads_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (w_ctrl),
        .i_item     (i_in_item),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
